### hw/rtl/aabb_clip_space_cull_unit_assert.svh
// ----------------------------------------------------------------------------
// aabb clip space cull assertion macros
// shared property forms for the cull pipeline checks
// ----------------------------------------------------------------------------
`ifndef AABB_CLIP_SPACE_CULL_UNIT_ASSERT_SVH
`define AABB_CLIP_SPACE_CULL_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ACC_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("cull unit check failed");

// next-cycle implication, checked outside reset
`define ACC_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("cull unit check failed");

`endif

### hw/rtl/aabbcc_pkg.sv
// ----------------------------------------------------------------------------
// aabbcc_pkg
// shared constants for the box clip space cull unit
// ----------------------------------------------------------------------------
package aabbcc_pkg;

    // default fraction bits of the fixed point format
    localparam int FRAC_BITS_DEF = 16;

    // geometry counts
    localparam int NUM_CORNERS = 8;
    localparam int NUM_PLANES  = 6;

    // configuration register file
    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;

    // packed word and element widths
    localparam int WORD_W      = 64;
    localparam int ELEM_W      = 32;

endpackage

### hw/rtl/aabb_clip_space_cull_unit.sv
// ----------------------------------------------------------------------------
// aabb_clip_space_cull_unit
// box versus clip volume cull through model and light matrices
// ----------------------------------------------------------------------------
// usage:
//   input channel s_* carries one box item: the model matrix in eight packed
//   words and the box corners in three. the light matrix sits in eight
//   registers written through cfg_wr_en / cfg_wr_index / cfg_wr_data;
//   the user must write them only while idle; the block does not enforce it.
//   the m_* channel returns one box_visible bit per item. the light and model
//   matrices are first folded into one combined matrix, then the eight
//   corners are formed from per-axis products.
// stages: six register stages from acceptance to m_valid (matrix product,
//   row sum, split products, recombine, corner sums, plane test), one item each.
// throughput: one item per cycle unless the output is held (see stall).
// reset: all stages empty and the light matrix cleared to zero.
// stall: when m_valid is high and m_ready low the whole pipeline holds and
//   s_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module aabb_clip_space_cull_unit #(
    parameter int FRAC_BITS = aabbcc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [aabbcc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [aabbcc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input item
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [63:0]                         s_model_m00_m01,
    input  logic [63:0]                         s_model_m02_m03,
    input  logic [63:0]                         s_model_m10_m11,
    input  logic [63:0]                         s_model_m12_m13,
    input  logic [63:0]                         s_model_m20_m21,
    input  logic [63:0]                         s_model_m22_m23,
    input  logic [63:0]                         s_model_m30_m31,
    input  logic [63:0]                         s_model_m32_m33,
    input  logic [63:0]                         s_box_min_x_y,
    input  logic [63:0]                         s_box_min_z_max_x,
    input  logic [63:0]                         s_box_max_y_z,
    // result item
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_box_visible
);

`include "aabb_clip_space_cull_unit_assert.svh"

    localparam int EW     = aabbcc_pkg::ELEM_W;
    localparam int NCFG   = aabbcc_pkg::NUM_CFG;
    localparam int NCOR   = aabbcc_pkg::NUM_CORNERS;
    localparam int NPL    = aabbcc_pkg::NUM_PLANES;
    localparam int LMW    = 2 * EW;              // one light x model product
    localparam int NW     = LMW + 2;             // sum of four products
    localparam int HIW    = NW - EW;             // upper slice of combined element
    localparam int PLW    = EW + 1 + EW;         // low slice product
    localparam int PHW    = HIW + EW;            // high slice product
    localparam int PW     = NW + EW;             // full element times coordinate
    localparam int KW     = NW + FRAC_BITS;      // w column term
    localparam int CW     = ((PW > KW) ? PW : KW) + 3;
    localparam int NSTG   = 6;

    // light matrix registers
    logic [aabbcc_pkg::CFG_DATA_W-1:0] light_reg [NCFG];

    // pipeline control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            en;

    // stage 1: light times model products [r][c][j]
    logic signed [LMW-1:0] lm_reg  [4][4][4];
    logic signed [LMW-1:0] lm_next [4][4][4];
    logic signed [EW-1:0]  box1_reg [3][2];
    logic signed [EW-1:0]  box_in   [3][2];
    // stage 2: combined matrix [r][j]
    logic signed [NW-1:0]  n_reg  [4][4];
    logic signed [NW-1:0]  n_next [4][4];
    logic signed [EW-1:0]  box2_reg [3][2];
    // stage 3: split products [r][j][s]
    logic signed [PLW-1:0] pl_reg  [4][3][2];
    logic signed [PLW-1:0] pl_next [4][3][2];
    logic signed [PHW-1:0] ph_reg  [4][3][2];
    logic signed [PHW-1:0] ph_next [4][3][2];
    logic signed [NW-1:0]  n3_reg [4];
    // stage 4: recombined products and w column term
    logic signed [PW-1:0]  t_reg  [4][3][2];
    logic signed [PW-1:0]  t_next [4][3][2];
    logic signed [CW-1:0]  k_reg  [4];
    logic signed [CW-1:0]  k_next [4];
    // stage 5: clip coordinates per corner
    logic signed [CW-1:0]  clip_reg  [NCOR][4];
    logic signed [CW-1:0]  clip_next [NCOR][4];
    // stage 6: result
    logic                  vis_reg;
    logic                  vis_next;

    logic [63:0] model_w [NCFG];

    // whole pipeline moves unless the output item is held
    assign en       = !(vld_reg[NSTG-1] && !m_ready);
    assign s_ready  = en;
    assign m_valid  = vld_reg[NSTG-1];
    assign m_box_visible = vis_reg;
    assign vld_next = {vld_reg[NSTG-2:0], s_valid};

    assign model_w[0] = s_model_m00_m01;
    assign model_w[1] = s_model_m02_m03;
    assign model_w[2] = s_model_m10_m11;
    assign model_w[3] = s_model_m12_m13;
    assign model_w[4] = s_model_m20_m21;
    assign model_w[5] = s_model_m22_m23;
    assign model_w[6] = s_model_m30_m31;
    assign model_w[7] = s_model_m32_m33;

    // box coordinates [axis][min/max]
    assign box_in[0][0] = s_box_min_x_y[EW-1:0];
    assign box_in[1][0] = s_box_min_x_y[2*EW-1:EW];
    assign box_in[2][0] = s_box_min_z_max_x[EW-1:0];
    assign box_in[0][1] = s_box_min_z_max_x[2*EW-1:EW];
    assign box_in[1][1] = s_box_max_y_z[EW-1:0];
    assign box_in[2][1] = s_box_max_y_z[2*EW-1:EW];

    // configuration writes, out of range indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCFG; i++) begin
                light_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (cfg_wr_index < aabbcc_pkg::CFG_IDX_W'(NCFG))) begin
            light_reg[cfg_wr_index[2:0]] <= cfg_wr_data;
        end
    end

    // stage 1: every light element against every model element
    always_comb begin
        logic signed [EW-1:0] le;
        logic signed [EW-1:0] me;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                for (int j = 0; j < 4; j++) begin
                    le = light_reg[r*2 + c/2][(c%2)*EW +: EW];
                    me = model_w[c*2 + j/2][(j%2)*EW +: EW];
                    lm_next[r][c][j] = LMW'(le * me);
                end
            end
        end
    end

    // stage 2: combined matrix rows
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                n_next[r][j] = NW'(lm_reg[r][0][j]) + NW'(lm_reg[r][1][j])
                             + NW'(lm_reg[r][2][j]) + NW'(lm_reg[r][3][j]);
            end
        end
    end

    // stage 3: split wide element into two narrow products
    always_comb begin
        logic signed [EW:0]    nlo;
        logic signed [HIW-1:0] nhi;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 3; j++) begin
                for (int s = 0; s < 2; s++) begin
                    nlo = $signed({1'b0, n_reg[r][j][EW-1:0]});
                    nhi = n_reg[r][j][NW-1:EW];
                    pl_next[r][j][s] = PLW'(nlo * box2_reg[j][s]);
                    ph_next[r][j][s] = PHW'(nhi * box2_reg[j][s]);
                end
            end
        end
    end

    // stage 4: recombine slices, scale the w column
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 3; j++) begin
                for (int s = 0; s < 2; s++) begin
                    t_next[r][j][s] = (PW'(ph_reg[r][j][s]) <<< EW) + PW'(pl_reg[r][j][s]);
                end
            end
            k_next[r] = CW'(n3_reg[r]) <<< FRAC_BITS;
        end
    end

    // stage 5: clip position of each corner
    always_comb begin
        for (int i = 0; i < NCOR; i++) begin
            for (int r = 0; r < 4; r++) begin
                clip_next[i][r] = k_reg[r] + CW'(t_reg[r][0][i%2])
                                + CW'(t_reg[r][1][(i/2)%2]) + CW'(t_reg[r][2][(i/4)%2]);
            end
        end
    end

    // stage 6: plane tests, culled when all corners outside one plane
    always_comb begin
        logic [NPL-1:0]       all_out;
        logic signed [CW:0]   sum_w;
        logic signed [CW:0]   dif_w;
        all_out = '1;
        for (int i = 0; i < NCOR; i++) begin
            for (int k = 0; k < 3; k++) begin
                sum_w = (CW+1)'(clip_reg[i][k]) + (CW+1)'(clip_reg[i][3]);
                dif_w = (CW+1)'(clip_reg[i][k]) - (CW+1)'(clip_reg[i][3]);
                if (!(sum_w < 0)) begin
                    all_out[2*k] = 1'b0;
                end
                if (!(dif_w > 0)) begin
                    all_out[2*k+1] = 1'b0;
                end
            end
        end
        vis_next = !(|all_out);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (en) begin
            lm_reg   <= lm_next;
            box1_reg <= box_in;
            n_reg    <= n_next;
            box2_reg <= box1_reg;
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            for (int r = 0; r < 4; r++) begin
                n3_reg[r] <= n_reg[r][3];
            end
            t_reg    <= t_next;
            k_reg    <= k_next;
            clip_reg <= clip_next;
            vis_reg  <= vis_next;
        end
    end

    // pipeline checks
    `ACC_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0])
    `ACC_ASSERT_NXT(a_stall_holds, aclk, aresetn, !en, $stable(vld_reg))
    `ACC_ASSERT_NXT(a_valid_advance, aclk, aresetn, en, vld_reg[NSTG-1:1] == $past(vld_reg[NSTG-2:0]))
    `ACC_ASSERT_IMP(a_no_take_when_held, aclk, aresetn, m_valid && !m_ready, !s_ready)

endmodule

### bench/tb_aabb_clip_space_cull_unit.sv
// ----------------------------------------------------------------------------
// tb_aabb_clip_space_cull_unit
// self-checking bench for the box versus clip volume cull unit
// ----------------------------------------------------------------------------
// a directed table of boxes and matrices runs first, then random boxes under
// several light matrices. every accepted item is predicted with exact wide
// arithmetic and checked in order against the result channel, with random
// idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aabb_clip_space_cull_unit;

    localparam int FRAC = aabbcc_pkg::FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY = 6;

    // light register indexes
    typedef enum int {
        L_M00_M01 = 0, L_M02_M03 = 1, L_M10_M11 = 2, L_M12_M13 = 3,
        L_M20_M21 = 4, L_M22_M23 = 5, L_M30_M31 = 6, L_M32_M33 = 7,
        L_BEYOND = 9, L_FAR = 15
    } light_reg_t;

    typedef struct {
        logic [63:0] model [8];
        logic [63:0] box [3];
    } box_item_t;

    // directed row, expected visibility typed in where obvious
    typedef struct {
        box_item_t item;
        int        known;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [aabbcc_pkg::CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [aabbcc_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [63:0] s_word [11];
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_box_visible;

    logic [63:0] light_shadow [8];
    bit   visible_q [$];
    int   errors = 0;
    int   n_items = 0;
    int   n_results = 0;
    int   n_culled = 0;
    int   idle_pct = 33;
    int   stall_cnt = 0;
    bit   timed_out = 0;

    initial for (int i = 0; i < 11; i++) s_word[i] = '0;

    always #5 aclk = ~aclk;

    aabb_clip_space_cull_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_model_m00_m01(s_word[0]), .s_model_m02_m03(s_word[1]),
        .s_model_m10_m11(s_word[2]), .s_model_m12_m13(s_word[3]),
        .s_model_m20_m21(s_word[4]), .s_model_m22_m23(s_word[5]),
        .s_model_m30_m31(s_word[6]), .s_model_m32_m33(s_word[7]),
        .s_box_min_x_y(s_word[8]), .s_box_min_z_max_x(s_word[9]),
        .s_box_max_y_z(s_word[10]),
        .m_valid(m_valid), .m_ready(m_ready), .m_box_visible(m_box_visible)
    );

    // element (r,c) of a packed matrix
    function automatic logic signed [127:0] elem_of(logic [63:0] w [8], int r, int c);
        logic [63:0] word;
        word = w[r * 2 + c / 2];
        return (c % 2) ? 128'(signed'(word[63:32])) : 128'(signed'(word[31:0]));
    endfunction

    // exact clip transform of all corners and six plane counts
    function automatic bit box_visible_of(box_item_t it);
        logic signed [127:0] cmin [3], cmax [3], v [4], wv [4], cp [4];
        int cnt [6];
        bit vis;
        vis = 1;
        for (int k = 0; k < 6; k++) cnt[k] = 0;
        cmin[0] = 128'(signed'(it.box[0][31:0]));
        cmin[1] = 128'(signed'(it.box[0][63:32]));
        cmin[2] = 128'(signed'(it.box[1][31:0]));
        cmax[0] = 128'(signed'(it.box[1][63:32]));
        cmax[1] = 128'(signed'(it.box[2][31:0]));
        cmax[2] = 128'(signed'(it.box[2][63:32]));
        for (int i = 0; i < 8; i++) begin
            for (int a = 0; a < 3; a++) v[a] = ((i >> a) & 1) ? cmax[a] : cmin[a];
            v[3] = 128'sd1 <<< FRAC;
            for (int r = 0; r < 4; r++) begin
                wv[r] = 0;
                for (int c = 0; c < 4; c++) wv[r] += elem_of(it.model, r, c) * v[c];
            end
            for (int r = 0; r < 4; r++) begin
                cp[r] = 0;
                for (int c = 0; c < 4; c++) cp[r] += elem_of(light_shadow, r, c) * wv[c];
            end
            for (int k = 0; k < 3; k++) begin
                if (cp[k] + cp[3] < 0) cnt[2 * k]++;
                if (cp[k] - cp[3] > 0) cnt[2 * k + 1]++;
            end
        end
        for (int k = 0; k < 6; k++) if (cnt[k] == 8) vis = 0;
        return vis;
    endfunction

    function automatic logic [63:0] pack2(int lo, int hi);
        return {hi[31:0], lo[31:0]};
    endfunction

    function automatic logic [63:0] rand_word();
        logic [31:0] a, b;
        case ($urandom_range(0, 5))
            0: begin a = $urandom; b = $urandom; end
            1: begin a = 32'h7fffffff; b = 32'h80000000; end
            default: begin
                a = 32'($signed($urandom_range(0, 6 << FRAC)) - (3 << FRAC));
                b = 32'($signed($urandom_range(0, 6 << FRAC)) - (3 << FRAC));
            end
        endcase
        return {b, a};
    endfunction

    function automatic box_item_t identity_box(int lo, int hi);
        box_item_t it;
        for (int i = 0; i < 8; i++) it.model[i] = '0;
        it.model[0] = pack2(1 << FRAC, 0);
        it.model[2] = pack2(0, 1 << FRAC);
        it.model[5] = pack2(1 << FRAC, 0);
        it.model[7] = pack2(0, 1 << FRAC);
        it.box[0] = pack2(lo, lo);
        it.box[1] = pack2(lo, hi);
        it.box[2] = pack2(hi, hi);
        return it;
    endfunction

    // one write, then the port idles with the write enable low before returning
    task automatic write_light(int idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= aabbcc_pkg::CFG_IDX_W'(idx);
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < aabbcc_pkg::NUM_CFG) light_shadow[idx] = val;
        @(posedge aclk);
    endtask

    task automatic load_identity_light(int scale);
        write_light(L_M00_M01, pack2(scale, 0));
        write_light(L_M02_M03, 0);
        write_light(L_M10_M11, pack2(0, scale));
        write_light(L_M12_M13, 0);
        write_light(L_M20_M21, 0);
        write_light(L_M22_M23, pack2(scale, 0));
        write_light(L_M30_M31, 0);
        write_light(L_M32_M33, pack2(0, scale));
    endtask

    // wait for the pipe to drain before touching the registers
    task automatic drain();
        s_valid <= 1'b0;
        while (visible_q.size() != 0 && !timed_out) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // valid stays high after an accept until the next item or an idle cycle
    task automatic send_box(box_item_t it, int known);
        bit exp;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        for (int i = 0; i < 8; i++) s_word[i] <= it.model[i];
        for (int i = 0; i < 3; i++) s_word[8 + i] <= it.box[i];
        s_valid <= 1'b1;
        exp = box_visible_of(it);
        if (known >= 0 && exp != known[0]) begin
            $display("%0t table row mismatch: expected %0d actual %0d", $time, known, exp);
            errors++;
        end
        do @(posedge aclk); while (!s_ready && !timed_out);
        visible_q = {visible_q, exp};
        n_items++;
    endtask

    // result side: random stalls and in-order compare
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (visible_q.size() == 0) begin
                    $display("%0t unexpected item: expected none actual %0d", $time,
                             m_box_visible);
                    errors++;
                end else begin
                    bit e;
                    e = visible_q.pop_front();
                    if (e != m_box_visible) begin
                        $display("%0t box_visible mismatch: expected %0d actual %0d",
                                 $time, e, m_box_visible);
                        errors++;
                    end
                    if (!e) n_culled++;
                end
                n_results++;
            end
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !s_valid && visible_q.size() == 0)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        dir_row_t rows [$];
        dir_row_t row;
        box_item_t it;
        int one;
        one = 1 << FRAC;
        for (int i = 0; i < 8; i++) light_shadow[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset the light matrix is zero: every clip coord is 0, visible
        send_box(identity_box(-one, one), 1);
        drain();
        load_identity_light(one);

        // directed table
        row.item = identity_box(-one, one);          row.known = 1; rows = {rows, row};
        row.item = identity_box(2 * one, 3 * one);   row.known = 0; rows = {rows, row};
        row.item = identity_box(-3 * one, -2 * one); row.known = 0; rows = {rows, row};
        row.item = identity_box(one, 2 * one);       row.known = 1; rows = {rows, row};
        row.item = identity_box(-2 * one, -one);     row.known = 1; rows = {rows, row};
        row.item = identity_box(one / 2, -one / 2);  row.known = 1; rows = {rows, row};
        row.item = identity_box(3 * one, -3 * one);  row.known = 1; rows = {rows, row};
        row.item = identity_box(32'h7fffffff, 32'h7fffffff); row.known = 0;
        rows = {rows, row};
        row.item = identity_box(32'h80000000, 32'h80000000); row.known = 0;
        rows = {rows, row};
        for (int i = 0; i < 8; i++) row.item.model[i] = 64'hffffffff_ffffffff;
        row.item.box[0] = 64'h7fffffff_80000000; row.item.box[1] = '1; row.item.box[2] = '0;
        row.known = -1; rows = {rows, row};
        for (int i = 0; i < 8; i++) row.item.model[i] = 64'h80000000_7fffffff;
        row.item.box[0] = 64'h80000000_80000000; row.item.box[1] = 64'h7fffffff_7fffffff;
        row.item.box[2] = 64'h80000000_7fffffff; rows = {rows, row};
        it = identity_box(-one, one); it.model[7] = pack2(0, -one);
        row.item = it; row.known = -1; rows = {rows, row};
        it = identity_box(-one, one); it.model[7] = 0;
        row.item = it; rows = {rows, row};
        foreach (rows[i]) send_box(rows[i].item, rows[i].known);

        // random phases with varied light matrices, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    load_identity_light(one);
                    // out-of-range indexes must leave the matrix alone
                    write_light(L_BEYOND, '1);
                    write_light(L_FAR, '1);
                end
                1: for (int i = 0; i < 8; i++) write_light(i, '1);
                2: for (int i = 0; i < 8; i++) write_light(i, 64'h80000000_7fffffff);
                3: load_identity_light(one / 4);
                default: for (int i = 0; i < 8; i++) write_light(i, rand_word());
            endcase
            idle_pct = (ph == 2) ? 0 : 33;
            for (int n = 0; n < 340; n++) begin
                for (int i = 0; i < 8; i++) it.model[i] = rand_word();
                if ($urandom_range(0, 1)) begin
                    it.model[0] = pack2(one, 0); it.model[2] = pack2(0, one);
                    it.model[4] = 0; it.model[5] = pack2(one, 0);
                    it.model[6] = 0; it.model[7] = pack2(0, one);
                end
                for (int i = 0; i < 3; i++) it.box[i] = rand_word();
                send_box(it, -1);
                // hold off once until the pipe is empty
                if (ph == 1 && n == 100) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (visible_q.size() != 0);
                end
            end
        end

        drain();
        $display("ran %0d boxes (%0d culled, %0d results) over several light settings",
                 n_items, n_culled, n_results);
        if (errors == 0 && visible_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/aabbcc_pkg.sv
hw/rtl/aabb_clip_space_cull_unit.sv
bench/tb_aabb_clip_space_cull_unit.sv
